[rtl/fsf_pkg.sv]
`default_nettype none

package fsf_pkg;

  // converter and servo ranges
  localparam int unsigned SampleW  = 10;
  localparam int unsigned LevelW   = 11;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned TactW    = 7;
  localparam int unsigned GainW    = 9;
  localparam int unsigned CmdW     = 8;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SampleW-1:0] LEVEL_MAX      = 10'd1023;
  localparam logic [SampleW:0]   FORCE_DEADBAND = 11'd5;
  localparam logic [TactW-1:0]   TACT_MAX       = 7'd90;

  // item kinds carried on in_tuser
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_CMD  = 1'b1
  } action_t;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_SERVO_MIN   = 3'd0,
    REG_SERVO_MAX   = 3'd1,
    REG_FORCE_GAIN  = 3'd2,
    REG_BEND_GAIN   = 3'd3,
    REG_INTERVAL    = 3'd4,
    REG_FORCE_EN    = 3'd5,
    REG_BEND_EN     = 3'd6,
    REG_TACTILE_EN  = 3'd7
  } cfg_reg_t;

  // input item payload, first field in the highest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [CmdW-1:0]    bend_command;
    logic [SampleW-1:0] bend_sample;
    logic [SampleW-1:0] force_sample;
    logic [TimeW-1:0]   now_ms;
  } in_item_t;

  // result item payload, first field in the highest bits
  typedef struct packed {
    logic [LevelW-1:0] bend_level;
    logic [LevelW-1:0] force_level;
    logic              sampled;
    logic [TactW-1:0]  tactile_angle;
    logic              tactile_write;
    logic [AngleW-1:0] servo_angle;
    logic              servo_write;
  } out_item_t;

  // tactile step outcome handed back to the top level
  typedef struct packed {
    logic             move;
    logic [TactW-1:0] pos;
  } tact_res_t;

endpackage

`default_nettype wire

[rtl/fsf_smooth.sv]
`default_nettype none

module fsf_smooth (
  input  wire logic [fsf_pkg::SampleW-1:0] cur,
  input  wire logic [fsf_pkg::SampleW-1:0] sample,
  input  wire logic [fsf_pkg::GainW-1:0]   gain,
  output logic      [fsf_pkg::SampleW-1:0] value
);

  logic signed [10:0] diff;
  logic signed [20:0] prod;
  logic signed [20:0] prod_adj;
  logic signed [12:0] step;
  logic signed [12:0] sum;

  // gain times difference, divided by 256 toward zero
  always_comb begin
    diff     = $signed({1'b0, sample}) - $signed({1'b0, cur});
    prod     = diff * $signed({1'b0, gain});
    prod_adj = prod[20] ? (prod + 21'sd255) : prod;
    step     = prod_adj[20:8];
    sum      = $signed({3'b000, cur}) + step;
  end

  // saturate into the converter range
  always_comb begin
    if (sum[12]) begin
      value = '0;
    end else if (sum > $signed({3'b000, fsf_pkg::LEVEL_MAX})) begin
      value = fsf_pkg::LEVEL_MAX;
    end else begin
      value = sum[9:0];
    end
  end

endmodule

`default_nettype wire

[rtl/fsf_tactile.sv]
`default_nettype none

module fsf_tactile (
  input  wire logic [fsf_pkg::SampleW-1:0] prev_force,
  input  wire logic [fsf_pkg::SampleW-1:0] force_now,
  input  wire logic [fsf_pkg::TactW-1:0]   pos,
  output fsf_pkg::tact_res_t               res
);

  logic signed [10:0] diff;
  logic        [10:0] mag;
  logic signed [10:0] half;
  logic signed [11:0] target;

  // half the force change, truncated toward zero
  always_comb begin
    diff   = $signed({1'b0, prev_force}) - $signed({1'b0, force_now});
    mag    = diff[10] ? 11'(-diff) : 11'(diff);
    half   = (diff + $signed({10'd0, diff[10]})) >>> 1;
    target = $signed({5'd0, pos}) - $signed({half[10], half});
  end

  // move only past the deadband, clamp to the servo range
  always_comb begin
    res.move = (mag > fsf_pkg::FORCE_DEADBAND);
    if (target[11]) begin
      res.pos = '0;
    end else if (target > $signed({5'd0, fsf_pkg::TACT_MAX})) begin
      res.pos = fsf_pkg::TACT_MAX;
    end else begin
      res.pos = target[6:0];
    end
  end

endmodule

`default_nettype wire

[rtl/fsf_servo_map.sv]
`default_nettype none

module fsf_servo_map (
  input  wire logic [fsf_pkg::AngleW-1:0] lo,
  input  wire logic [fsf_pkg::AngleW-1:0] hi,
  input  wire logic [fsf_pkg::CmdW-1:0]   cmd,
  output logic      [fsf_pkg::AngleW-1:0] angle
);

  logic signed [8:0]  span;
  logic signed [17:0] prod;
  logic        [16:0] mag;
  logic        [16:0] qsum;
  logic        [7:0]  quot;
  logic        [7:0]  offs;

  // command times span, divided by 255 toward zero on the magnitude
  always_comb begin
    span  = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod  = $signed({1'b0, cmd}) * span;
    mag   = prod[17] ? 17'(-prod) : 17'(prod);
    qsum  = mag + 17'd1 + (mag >> 8);
    quot  = qsum[15:8];
    offs  = prod[17] ? 8'(~quot + 8'd1) : quot;
    angle = lo + offs;
  end

endmodule

`default_nettype wire

[rtl/finger_sensor_smoothing_feedback_unit.sv]
`default_nettype none

// channel   dir  width           contents
// in_       in   64 + 1 user     tick samples or bend command
// out_      out  40              servo, tactile and smoothed levels
// cfg_      in   3 idx, 16 data  register writes, no read-back
//
// one item per cycle while the output is not stalled; an item waits in the input
// register and its result is registered in the output register
// all arithmetic and the state update happen in the combinational logic between
// the two registers, so back-to-back ticks see each other's state
// reset (rst_n low, synchronous) clears both stages and state, presets config
// a stalled output holds both stages; in_tready drops only when both are full

module finger_sensor_smoothing_feedback_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // config write port
  input  wire logic                          cfg_wr_en,
  input  wire logic [fsf_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [fsf_pkg::CfgDataW-1:0]  cfg_wdata,
  // input stream
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // now_ms[31:0], force_sample[41:32], bend_sample[51:42],
  // bend_command[59:52], zero[63:60]
  input  wire logic [63:0]                   in_tdata,
  // action[0]
  input  wire logic                          in_tuser,
  // result stream
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // servo_write[0], servo_angle[8:1], tactile_write[9],
  // tactile_angle[16:10], sampled[17], force_level[28:18], bend_level[39:29]
  output logic [39:0]                        out_tdata
);

  // configuration registers
  logic [fsf_pkg::AngleW-1:0]    servo_min_r;
  logic [fsf_pkg::AngleW-1:0]    servo_max_r;
  logic [fsf_pkg::GainW-1:0]     force_gain_r;
  logic [fsf_pkg::GainW-1:0]     bend_gain_r;
  logic [fsf_pkg::IntervalW-1:0] interval_r;
  logic                          force_en_r;
  logic                          bend_en_r;
  logic                          tact_en_r;

  // filter state
  logic [fsf_pkg::TimeW-1:0]   last_time_r;
  logic [fsf_pkg::SampleW-1:0] force_sm_r;
  logic [fsf_pkg::SampleW-1:0] bend_sm_r;
  logic [fsf_pkg::SampleW-1:0] prev_force_r;
  logic [fsf_pkg::TactW-1:0]   tact_pos_r;
  logic                        seeded_r;

  // pipeline registers
  logic               in_valid_r;
  fsf_pkg::in_item_t  in_item_r;
  fsf_pkg::action_t   in_act_r;
  logic               out_valid_r;
  fsf_pkg::out_item_t out_item_r;

  logic               adv;
  logic               take;
  logic               load;

  logic [fsf_pkg::TimeW-1:0]   elapsed;
  logic                        tick_ok;
  logic [fsf_pkg::SampleW-1:0] force_base;
  logic [fsf_pkg::SampleW-1:0] bend_base;
  logic [fsf_pkg::SampleW-1:0] force_step;
  logic [fsf_pkg::SampleW-1:0] bend_step;
  logic [fsf_pkg::SampleW-1:0] force_new;
  logic [fsf_pkg::SampleW-1:0] bend_new;
  logic [fsf_pkg::SampleW-1:0] force_out;
  logic [fsf_pkg::SampleW-1:0] bend_out;
  logic [fsf_pkg::AngleW-1:0]  cmd_angle;
  fsf_pkg::tact_res_t          tact;
  logic                        tact_wr;
  logic [fsf_pkg::TactW-1:0]   tact_out;
  fsf_pkg::out_item_t          res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_min_r  <= 8'd0;
      servo_max_r  <= 8'd180;
      force_gain_r <= 9'd64;
      bend_gain_r  <= 9'd64;
      interval_r   <= 16'd10;
      force_en_r   <= 1'b0;
      bend_en_r    <= 1'b0;
      tact_en_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (fsf_pkg::cfg_reg_t'(cfg_index))
        fsf_pkg::REG_SERVO_MIN:  servo_min_r  <= cfg_wdata[7:0];
        fsf_pkg::REG_SERVO_MAX:  servo_max_r  <= cfg_wdata[7:0];
        fsf_pkg::REG_FORCE_GAIN: force_gain_r <= cfg_wdata[8:0];
        fsf_pkg::REG_BEND_GAIN:  bend_gain_r  <= cfg_wdata[8:0];
        fsf_pkg::REG_INTERVAL:   interval_r   <= cfg_wdata;
        fsf_pkg::REG_FORCE_EN:   force_en_r   <= cfg_wdata[0];
        fsf_pkg::REG_BEND_EN:    bend_en_r    <= cfg_wdata[0];
        fsf_pkg::REG_TACTILE_EN: tact_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // handshake: both stages move whenever the output slot frees up
  assign adv       = !out_valid_r || out_tready;
  assign take      = in_valid_r && adv;
  assign load      = in_tvalid && in_tready;
  assign in_tready = !in_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (load) begin
      in_valid_r <= 1'b1;
    end else if (adv) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item_r <= fsf_pkg::in_item_t'(in_tdata);
      in_act_r  <= fsf_pkg::action_t'(in_tuser);
    end
  end

  // interval check on wrapped time
  always_comb begin
    elapsed = in_item_r.now_ms - last_time_r;
    tick_ok = (in_act_r == fsf_pkg::ACT_TICK) &&
              (elapsed > {16'd0, interval_r});
  end

  // the first accepted tick seeds both filters from its samples
  assign force_base = seeded_r ? force_sm_r : in_item_r.force_sample;
  assign bend_base  = seeded_r ? bend_sm_r  : in_item_r.bend_sample;

  fsf_smooth u_force_smooth (
    .cur    (force_base),
    .sample (in_item_r.force_sample),
    .gain   (force_gain_r),
    .value  (force_step)
  );

  fsf_smooth u_bend_smooth (
    .cur    (bend_base),
    .sample (in_item_r.bend_sample),
    .gain   (bend_gain_r),
    .value  (bend_step)
  );

  assign force_new = force_en_r ? force_step : force_base;
  assign bend_new  = bend_en_r  ? bend_step  : bend_base;

  fsf_tactile u_tactile (
    .prev_force (prev_force_r),
    .force_now  (force_new),
    .pos        (tact_pos_r),
    .res        (tact)
  );

  fsf_servo_map u_servo_map (
    .lo    (servo_min_r),
    .hi    (servo_max_r),
    .cmd   (in_item_r.bend_command),
    .angle (cmd_angle)
  );

  // result assembly from the post-update state
  always_comb begin
    tact_wr   = tick_ok && tact_en_r && tact.move;
    tact_out  = tact_wr ? tact.pos : tact_pos_r;
    force_out = tick_ok ? force_new : force_sm_r;
    bend_out  = tick_ok ? bend_new  : bend_sm_r;

    res.servo_write   = (in_act_r == fsf_pkg::ACT_CMD);
    res.servo_angle   = (in_act_r == fsf_pkg::ACT_CMD) ? cmd_angle : '0;
    res.tactile_write = tact_wr;
    res.tactile_angle = tact_out;
    res.sampled       = tick_ok;
    res.force_level   = force_en_r ? {1'b0, force_out} : '1;
    res.bend_level    = bend_en_r  ? {1'b0, bend_out}  : '1;
  end

  // state update on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r  <= '0;
      force_sm_r   <= '0;
      bend_sm_r    <= '0;
      prev_force_r <= '0;
      tact_pos_r   <= '0;
      seeded_r     <= 1'b0;
    end else if (take && tick_ok) begin
      last_time_r <= in_item_r.now_ms;
      force_sm_r  <= force_new;
      bend_sm_r   <= bend_new;
      seeded_r    <= 1'b1;
      if (tact_en_r) begin
        prev_force_r <= force_new;
      end
      if (tact_wr) begin
        tact_pos_r <= tact.pos;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r;

  // tactile position never leaves the servo range
  assert property (@(posedge clk) disable iff (!rst_n)
    tact_pos_r <= fsf_pkg::TACT_MAX)
    else $error("tactile position out of range");

  // a command item leaves the filter state untouched
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_act_r == fsf_pkg::ACT_CMD) |=>
      ($stable(last_time_r) && $stable(force_sm_r) && $stable(tact_pos_r)))
    else $error("command item changed filter state");

  // once seeded, the filters stay seeded
  assert property (@(posedge clk) disable iff (!rst_n)
    seeded_r |=> seeded_r)
    else $error("seed flag cleared");

  // a result is never both a servo command and a sample
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_item_r.servo_write && out_item_r.sampled))
    else $error("result marked as command and sample");

  // a free output slot always lets a new item in
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with output ready");

endmodule

`default_nettype wire
